// ===== rtl/unpf_pkg.sv =====
// ----------------------------------------------------------------------------
// unpf_pkg: shared types and constants of the NAV-PVT frame receiver
// Parser phases, queue item layout, register codes and the byte-to-word map.
// ----------------------------------------------------------------------------
package unpf_pkg;

   localparam int NWORDS      = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND = 8'h62;
   localparam logic [7:0]  PVT_CLASS   = 8'h01;
   localparam logic [7:0]  PVT_ID      = 8'h07;
   localparam logic [15:0] PVT_LEN     = 16'd92;
   localparam logic [7:0]  FIX_2D      = 8'd2;
   localparam logic [7:0]  FIX_3D      = 8'd3;

   localparam logic [4:0] WORD_FIX_TYPE = 5'd1;
   localparam logic [4:0] WORD_FIX_OK   = 5'd2;
   localparam logic [4:0] WORD_NUM_SV   = 5'd3;
   localparam logic [4:0] WORD_H_ACC    = 5'd8;
   localparam logic [4:0] WORD_V_ACC    = 5'd9;
   localparam logic [4:0] WORD_LAST     = 5'd16;

   localparam logic [2:0] CSR_ONLINE_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_NAV_MIN_SATS   = 3'd1;
   localparam logic [2:0] CSR_NAV_MAX_HACC   = 3'd2;
   localparam logic [2:0] CSR_NAV_MAX_VACC   = 3'd3;
   localparam logic [2:0] CSR_NAV_MAX_AGE    = 3'd4;

   localparam logic [15:0] RST_ONLINE_TIMEOUT = 16'd1000;
   localparam logic [7:0]  RST_NAV_MIN_SATS   = 8'd6;
   localparam logic [31:0] RST_NAV_MAX_HACC   = 32'd5000;
   localparam logic [31:0] RST_NAV_MAX_VACC   = 32'd10000;
   localparam logic [15:0] RST_NAV_MAX_AGE    = 16'd500;

   localparam logic [6:0] WORD_OFF [NWORDS] = '{
      7'd0, 7'd20, 7'd21, 7'd23, 7'd24, 7'd28, 7'd32, 7'd36, 7'd40,
      7'd44, 7'd48, 7'd52, 7'd56, 7'd60, 7'd64, 7'd68, 7'd72};

   typedef enum logic [3:0] {
      PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN1, PH_LEN2,
      PH_PAYLOAD, PH_CKA, PH_CKB
   } phase_type;

   typedef logic [NWORDS-1:0][31:0] words_type;

   typedef struct packed {
      logic        good;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [15:0] online_timeout_ms;
      logic [7:0]  nav_min_satellites;
      logic [31:0] nav_max_horiz_acc_mm;
      logic [31:0] nav_max_vert_acc_mm;
      logic [15:0] nav_max_age_ms;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic [4:0] word;
      logic [1:0] lane;
   } lane_map_type;

   function automatic logic word_is_byte(input logic [4:0] w);
      return (w == WORD_FIX_TYPE) || (w == WORD_FIX_OK) || (w == WORD_NUM_SV);
   endfunction

   // Find which word and byte lane a payload offset lands in.
   function automatic lane_map_type map_byte(input logic [6:0] off);
      lane_map_type m;
      logic [7:0]   lo;
      logic [7:0]   hi;
      m = '0;
      for (int w = 0; w < NWORDS; w++) begin
         lo = {1'b0, WORD_OFF[w]};
         hi = lo + (word_is_byte(5'(w)) ? 8'd1 : 8'd4);
         if ({1'b0, off} >= lo && {1'b0, off} < hi) begin
            m.hit  = 1'b1;
            m.word = 5'(w);
            m.lane = 2'({1'b0, off} - lo);
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/unpf_fifo.sv =====
// ----------------------------------------------------------------------------
// unpf_fifo: short item queue between parser and emitter
// Holds item records so either side may stall on its own.
// ----------------------------------------------------------------------------
module unpf_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  unpf_pkg::item_type push_item,
   input  logic               pop,
   output unpf_pkg::item_type head_item,
   output logic               empty,
   output logic               full
);

   localparam int CW = $clog2(unpf_pkg::QUEUE_DEPTH + 1);

   unpf_pkg::item_type                mem_ff [unpf_pkg::QUEUE_DEPTH];
   logic [unpf_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [unpf_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                     count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(unpf_pkg::QUEUE_DEPTH));
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/unpf_front.sv =====
// ----------------------------------------------------------------------------
// unpf_front: UBX frame parser
// Tracks sync, header, payload and Fletcher sums; captures NAV-PVT words.
// ----------------------------------------------------------------------------
module unpf_front #(
   parameter int MAX_PAYLOAD_BYTES = 92
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic                action,
   input  logic [7:0]          rx_byte,
   output logic                good,
   output logic                at_ckb,
   output logic                frame_full,
   input  logic                frame_release,
   output unpf_pkg::words_type frame_words
);

   localparam int          CW      = $clog2(MAX_PAYLOAD_BYTES + 1);
   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_BYTES);

   unpf_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          class_ff, class_in;
   logic [7:0]          id_ff, id_in;
   logic [15:0]         len_ff, len_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [7:0]          sum_a_ff, sum_a_in;
   logic [7:0]          sum_b_ff, sum_b_in;
   unpf_pkg::words_type shadow_ff, shadow_in;
   unpf_pkg::words_type frame_ff;
   logic                full_ff, full_in;

   logic                 take_byte;
   logic [15:0]          len_full;
   logic [CW-1:0]        cnt_inc;
   logic [7:0]           add_a;
   logic [7:0]           add_b;
   unpf_pkg::lane_map_type map;

   assign take_byte   = take && !action;
   assign len_full    = {rx_byte, len_ff[7:0]};
   assign cnt_inc     = cnt_ff + 1'b1;
   assign add_a       = sum_a_ff + rx_byte;
   assign add_b       = sum_b_ff + add_a;
   assign map         = unpf_pkg::map_byte(cnt_ff[6:0]);
   assign at_ckb      = (phase_ff == unpf_pkg::PH_CKB);
   assign frame_full  = full_ff;
   assign frame_words = frame_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take_byte) begin
         unique case (phase_ff)
            unpf_pkg::PH_SYNC1:
               if (rx_byte == unpf_pkg::SYNC_FIRST) phase_in = unpf_pkg::PH_SYNC2;
            unpf_pkg::PH_SYNC2:
               phase_in = (rx_byte == unpf_pkg::SYNC_SECOND) ? unpf_pkg::PH_CLASS
                                                            : unpf_pkg::PH_SYNC1;
            unpf_pkg::PH_CLASS: phase_in = unpf_pkg::PH_ID;
            unpf_pkg::PH_ID:    phase_in = unpf_pkg::PH_LEN1;
            unpf_pkg::PH_LEN1:  phase_in = unpf_pkg::PH_LEN2;
            unpf_pkg::PH_LEN2: begin
               priority if (len_full > MAX_LEN) phase_in = unpf_pkg::PH_SYNC1;
               else if (len_full == '0)         phase_in = unpf_pkg::PH_CKA;
               else                             phase_in = unpf_pkg::PH_PAYLOAD;
            end
            unpf_pkg::PH_PAYLOAD:
               if ({{(32-CW){1'b0}}, cnt_inc} >= {16'b0, len_ff})
                  phase_in = unpf_pkg::PH_CKA;
            unpf_pkg::PH_CKA:
               phase_in = (rx_byte == sum_a_ff) ? unpf_pkg::PH_CKB : unpf_pkg::PH_SYNC1;
            unpf_pkg::PH_CKB: phase_in = unpf_pkg::PH_SYNC1;
            default:          phase_in = unpf_pkg::PH_SYNC1;
         endcase
      end
   end

   // header, sums, payload capture
   always_comb begin
      logic clr;
      clr       = 1'b0;
      good      = 1'b0;
      class_in  = class_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      shadow_in = shadow_ff;
      if (take_byte) begin
         unique case (phase_ff)
            unpf_pkg::PH_SYNC1: ;
            unpf_pkg::PH_SYNC2:
               if (rx_byte == unpf_pkg::SYNC_SECOND) begin
                  sum_a_in = '0;
                  sum_b_in = '0;
               end
            unpf_pkg::PH_CLASS: begin
               class_in = rx_byte;
               sum_a_in = add_a;
               sum_b_in = add_b;
            end
            unpf_pkg::PH_ID: begin
               id_in    = rx_byte;
               sum_a_in = add_a;
               sum_b_in = add_b;
            end
            unpf_pkg::PH_LEN1: begin
               len_in   = {8'b0, rx_byte};
               sum_a_in = add_a;
               sum_b_in = add_b;
            end
            unpf_pkg::PH_LEN2: begin
               len_in   = len_full;
               cnt_in   = '0;
               sum_a_in = add_a;
               sum_b_in = add_b;
               clr      = (len_full > MAX_LEN);
            end
            unpf_pkg::PH_PAYLOAD: begin
               cnt_in   = cnt_inc;
               sum_a_in = add_a;
               sum_b_in = add_b;
               if ({{(32-CW){1'b0}}, cnt_ff} < {16'b0, unpf_pkg::PVT_LEN} && map.hit)
                  shadow_in[map.word][8*map.lane +: 8] = rx_byte;
            end
            unpf_pkg::PH_CKA:
               clr = (rx_byte != sum_a_ff);
            unpf_pkg::PH_CKB: begin
               good = (rx_byte == sum_b_ff) && (class_ff == unpf_pkg::PVT_CLASS) &&
                      (id_ff == unpf_pkg::PVT_ID) && (len_ff == unpf_pkg::PVT_LEN);
               clr  = 1'b1;
            end
            default: clr = 1'b1;
         endcase
      end
      if (clr) begin
         class_in = '0;
         id_in    = '0;
         len_in   = '0;
         cnt_in   = '0;
         sum_a_in = '0;
         sum_b_in = '0;
      end
      full_in = full_ff;
      if (frame_release) full_in = 1'b0;
      if (good)          full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= unpf_pkg::PH_SYNC1;
         class_ff <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      shadow_ff <= shadow_in;
      if (good) begin
         frame_ff <= shadow_ff;
      end
   end

endmodule

// ===== rtl/unpf_back.sv =====
// ----------------------------------------------------------------------------
// unpf_back: result emitter and fix monitor
// Drains queued items, sends NAV-PVT words and status, keeps the fix record.
// ----------------------------------------------------------------------------
module unpf_back (
   input  logic                clock,
   input  logic                reset,
   input  unpf_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  unpf_pkg::item_type  q_head,
   output logic                q_pop,
   input  unpf_pkg::words_type frame_words,
   output logic                frame_release,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [4:0]          rsp_word_index,
   output logic [31:0]         rsp_word_value,
   output logic                rsp_online,
   output logic                rsp_has_valid_fix,
   output logic                rsp_usable_for_nav,
   output logic                rsp_last
);

   logic [4:0]  idx_ff, idx_in;
   logic [31:0] fix_time_ff;
   logic [7:0]  fix_kind_ff;
   logic        fix_ok_ff;
   logic [7:0]  sats_ff;
   logic [31:0] hacc_ff;
   logic [31:0] vacc_ff;

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [4:0]  windex_ff, windex_in;
   logic [31:0] wvalue_ff, wvalue_in;
   logic        online_ff, online_in;
   logic        vfix_ff, vfix_in;
   logic        usable_ff, usable_in;
   logic        last_ff, last_in;

   logic        load;
   logic        emit_word;
   logic [31:0] raw;
   logic [31:0] word_val;
   logic [31:0] age;
   logic        on;

   assign load      = !valid_ff || !rsp_stall;
   assign emit_word = q_head.good && (idx_ff <= unpf_pkg::WORD_LAST);
   assign raw       = frame_words[idx_ff];
   assign age       = q_head.now_ms - fix_time_ff;
   assign on        = (fix_time_ff != '0) && (age <= {16'b0, cfg.online_timeout_ms});

   always_comb begin
      priority if (idx_ff == unpf_pkg::WORD_FIX_OK) word_val = {31'b0, raw[0]};
      else if (unpf_pkg::word_is_byte(idx_ff))      word_val = {24'b0, raw[7:0]};
      else                                          word_val = raw;
   end

   always_comb begin
      valid_in      = valid_ff;
      kind_in       = kind_ff;
      windex_in     = windex_ff;
      wvalue_in     = wvalue_ff;
      online_in     = online_ff;
      vfix_in       = vfix_ff;
      usable_in     = usable_ff;
      last_in       = last_ff;
      idx_in        = idx_ff;
      q_pop         = 1'b0;
      frame_release = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (emit_word) begin
               kind_in       = 1'b1;
               windex_in     = idx_ff;
               wvalue_in     = word_val;
               online_in     = 1'b0;
               vfix_in       = 1'b0;
               usable_in     = 1'b0;
               last_in       = 1'b0;
               idx_in        = idx_ff + 1'b1;
               frame_release = (idx_ff == unpf_pkg::WORD_LAST);
            end else begin
               kind_in   = 1'b0;
               windex_in = '0;
               wvalue_in = '0;
               online_in = on;
               vfix_in   = on && (fix_kind_ff >= unpf_pkg::FIX_2D) && fix_ok_ff;
               usable_in = on && fix_ok_ff && (fix_kind_ff == unpf_pkg::FIX_3D) &&
                           (sats_ff >= cfg.nav_min_satellites) &&
                           (hacc_ff <= cfg.nav_max_horiz_acc_mm) &&
                           (vacc_ff <= cfg.nav_max_vert_acc_mm) &&
                           (age <= {16'b0, cfg.nav_max_age_ms});
               last_in   = 1'b1;
               idx_in    = '0;
               q_pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         idx_ff      <= '0;
         fix_time_ff <= '0;
         fix_kind_ff <= '0;
         fix_ok_ff   <= 1'b0;
         sats_ff     <= '0;
         hacc_ff     <= '0;
         vacc_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         // record the fix as the last word leaves
         if (frame_release) begin
            fix_time_ff <= q_head.now_ms;
            fix_kind_ff <= frame_words[unpf_pkg::WORD_FIX_TYPE][7:0];
            fix_ok_ff   <= frame_words[unpf_pkg::WORD_FIX_OK][0];
            sats_ff     <= frame_words[unpf_pkg::WORD_NUM_SV][7:0];
            hacc_ff     <= frame_words[unpf_pkg::WORD_H_ACC];
            vacc_ff     <= frame_words[unpf_pkg::WORD_V_ACC];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      windex_ff <= windex_in;
      wvalue_ff <= wvalue_in;
      online_ff <= online_in;
      vfix_ff   <= vfix_in;
      usable_ff <= usable_in;
      last_ff   <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_word_index     = windex_ff;
   assign rsp_word_value     = wvalue_ff;
   assign rsp_online         = online_ff;
   assign rsp_has_valid_fix  = vfix_ff;
   assign rsp_usable_for_nav = usable_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== rtl/ubx_nav_pvt_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ubx_nav_pvt_frame_receiver: UBX NAV-PVT frame receiver with fix monitor
// Parses a UBX byte stream, emits NAV-PVT words and fix status per item.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per transfer: a received byte with its millisecond
//  time, or a bare status refresh (req_action high). rsp_* returns results:
//  each item gives one status result with rsp_last set; a frame of class 1,
//  id 7, length 92 with good checksums first gives seventeen word results.
//  csr_* writes the limit registers; write only while the block is idle.
//  Throughput: one item per cycle while req_stall is low. The parser takes a
//  byte every cycle unless stalled and hands a record to a four-entry queue;
//  the emitter sends one result per cycle unless rsp_stall holds it, so a
//  good frame occupies the emitter for eighteen results as bytes keep arriving.
//  req_stall rises when the queue is full, or when a checksum byte is due
//  while the previous frame's words are still being sent.
//  rsp_stall holds the output register; the queue then fills behind it.
//  Reset clears parser, queue, fix record and loads the register defaults.
// ----------------------------------------------------------------------------
module ubx_nav_pvt_frame_receiver #(
   parameter int MAX_PAYLOAD_BYTES = 92
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [4:0]  rsp_word_index,
   output logic [31:0] rsp_word_value,
   output logic        rsp_online,
   output logic        rsp_has_valid_fix,
   output logic        rsp_usable_for_nav,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   unpf_pkg::cfg_type   cfg_ff;
   unpf_pkg::item_type  push_item;
   unpf_pkg::item_type  head_item;
   unpf_pkg::words_type frame_words;
   logic                take;
   logic                good;
   logic                at_ckb;
   logic                frame_full;
   logic                frame_release;
   logic                q_empty;
   logic                q_full;
   logic                q_pop;

   // hold off a checksum byte that could finish a frame while the buffer is busy
   assign req_stall = q_full || (frame_full && at_ckb);
   assign take      = req_valid && !req_stall;
   assign push_item = '{good: good, now_ms: req_now_ms};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.online_timeout_ms    <= unpf_pkg::RST_ONLINE_TIMEOUT;
         cfg_ff.nav_min_satellites   <= unpf_pkg::RST_NAV_MIN_SATS;
         cfg_ff.nav_max_horiz_acc_mm <= unpf_pkg::RST_NAV_MAX_HACC;
         cfg_ff.nav_max_vert_acc_mm  <= unpf_pkg::RST_NAV_MAX_VACC;
         cfg_ff.nav_max_age_ms       <= unpf_pkg::RST_NAV_MAX_AGE;
      end else if (csr_write) begin
         unique case (csr_index)
            unpf_pkg::CSR_ONLINE_TIMEOUT: cfg_ff.online_timeout_ms    <= csr_data[15:0];
            unpf_pkg::CSR_NAV_MIN_SATS:   cfg_ff.nav_min_satellites   <= csr_data[7:0];
            unpf_pkg::CSR_NAV_MAX_HACC:   cfg_ff.nav_max_horiz_acc_mm <= csr_data;
            unpf_pkg::CSR_NAV_MAX_VACC:   cfg_ff.nav_max_vert_acc_mm  <= csr_data;
            unpf_pkg::CSR_NAV_MAX_AGE:    cfg_ff.nav_max_age_ms       <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   unpf_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .action       (req_action),
      .rx_byte      (req_rx_byte),
      .good         (good),
      .at_ckb       (at_ckb),
      .frame_full   (frame_full),
      .frame_release(frame_release),
      .frame_words  (frame_words)
   );

   unpf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .push_item(push_item),
      .pop      (q_pop),
      .head_item(head_item),
      .empty    (q_empty),
      .full     (q_full)
   );

   unpf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_head            (head_item),
      .q_pop             (q_pop),
      .frame_words       (frame_words),
      .frame_release     (frame_release),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_word_index    (rsp_word_index),
      .rsp_word_value    (rsp_word_value),
      .rsp_online        (rsp_online),
      .rsp_has_valid_fix (rsp_has_valid_fix),
      .rsp_usable_for_nav(rsp_usable_for_nav),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/unpf_checker.sv =====
// ----------------------------------------------------------------------------
// unpf_checker: port-level checks of the NAV-PVT frame receiver
// Watches the result channel for ordering and flag consistency.
// ----------------------------------------------------------------------------
module unpf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [4:0]  rsp_word_index,
   input logic [31:0] rsp_word_value,
   input logic        rsp_online,
   input logic        rsp_has_valid_fix,
   input logic        rsp_usable_for_nav,
   input logic        rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word_value) &&
      $stable(rsp_kind) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == !rsp_kind))
      else $error("last flag does not match result kind");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_word_index <= 5'd16 && !rsp_online)
      else $error("word result out of range or carries status");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_has_valid_fix || rsp_usable_for_nav) |-> rsp_online)
      else $error("fix flags set while offline");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_kind && rsp_word_index != 5'd16
      |=> rsp_valid && rsp_kind)
      else $error("word sequence interrupted");

endmodule

bind ubx_nav_pvt_frame_receiver unpf_checker u_unpf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_word_index    (rsp_word_index),
   .rsp_word_value    (rsp_word_value),
   .rsp_online        (rsp_online),
   .rsp_has_valid_fix (rsp_has_valid_fix),
   .rsp_usable_for_nav(rsp_usable_for_nav),
   .rsp_last          (rsp_last)
);
